[hdl/gat_pkg.sv]
// shared types and constants for the generation admission table
package gat_pkg;

    localparam int TableDepth   = 64;
    localparam int SlotW        = $clog2(TableDepth);
    localparam int CountW       = SlotW + 1;
    localparam int MaxFirstHops = 4;
    localparam int HopIdxW      = $clog2(MaxFirstHops);
    localparam int HopCntW      = $clog2(MaxFirstHops + 1);

    // register indexes
    localparam logic [2:0] RegFactorSame = 3'd0;
    localparam logic [2:0] RegFactorNew  = 3'd1;
    localparam logic [2:0] RegBcastLimit = 3'd2;
    localparam logic [2:0] RegEntryCap   = 3'd3;
    localparam logic [2:0] RegInvalid    = 3'd4;

    // commands
    localparam logic CmdAccept    = 1'b0;
    localparam logic CmdBroadcast = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic load;        // capture request
        logic srch_start;  // set search index to zero
        logic srch_rd;     // issue key read at search index
        logic srch_next;   // advance search index
        logic evict;       // drop oldest entry
        logic create;      // write new entry
        logic hop_start;   // start hop list scan
        logic hop_rd;      // issue hop list read
        logic hop_next;    // advance hop scan
        logic mul;         // register products
        logic decide;      // apply admission / broadcast update
        logic note_hop;    // write hop to list
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_bcast;
        logic bcast_unlim;
        logic srch_done;   // index reached live count
        logic key_hit;     // read key matches
        logic full;        // live count at or above cap
        logic hop_done;    // scanned all listed hops
        logic hop_hit;     // listed hop matches
    } t_stat;

endpackage

[hdl/gat_datapath.sv]
// datapath: entry memories, search index, hop list and admission compare
module gat_datapath import gat_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_command,
    input  logic [31:0] i_source_address,
    input  logic [31:0] i_sequence_number,
    input  logic [7:0]  i_hop_count,
    input  logic [31:0] i_travel_time,
    input  logic [31:0] i_first_hop,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    output logic        o_admitted,
    output logic        o_new_generation
);

    // configuration registers
    logic [15:0] r_factor_same, r_factor_new;
    logic [8:0]  r_bcast_limit;
    logic [6:0]  r_entry_cap;
    logic [31:0] r_invalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_factor_same <= 16'd384;
            r_factor_new  <= 16'd512;
            r_bcast_limit <= 9'h1FF;
            r_entry_cap   <= '0;
            r_invalid     <= 32'hFFFF_FFFF;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                RegFactorSame: r_factor_same <= i_cfg_data[15:0];
                RegFactorNew:  r_factor_new  <= i_cfg_data[15:0];
                RegBcastLimit: r_bcast_limit <= i_cfg_data[8:0];
                RegEntryCap:   r_entry_cap   <= i_cfg_data[6:0];
                RegInvalid:    r_invalid     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // request capture
    logic        r_cmd;
    logic [31:0] r_src, r_seq, r_time, r_hop;
    logic [7:0]  r_hops;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd  <= i_command;
            r_src  <= i_source_address;
            r_seq  <= i_sequence_number;
            r_hops <= i_hop_count;
            r_time <= i_travel_time;
            r_hop  <= i_first_hop;
        end
    end

    // ring pointers
    logic [SlotW-1:0]  r_oldest;
    logic [CountW-1:0] r_live;
    logic [CountW-1:0] r_idx;
    logic [SlotW-1:0]  r_slot;
    logic [CountW-1:0] cap;
    logic [SlotW-1:0]  srch_slot, new_slot;

    assign cap = (r_entry_cap == '0 || r_entry_cap > 7'(TableDepth))
        ? CountW'(TableDepth) : CountW'(r_entry_cap);
    assign srch_slot = r_oldest + r_idx[SlotW-1:0];
    assign new_slot  = r_oldest + r_live[SlotW-1:0];

    // entry memories
    logic [31:0]        mem_src  [TableDepth];
    logic [31:0]        mem_seq  [TableDepth];
    logic [7:0]         mem_hops [TableDepth];
    logic [31:0]        mem_time [TableDepth];
    logic [7:0]         mem_bc   [TableDepth];
    logic [HopCntW-1:0] mem_hcnt [TableDepth];
    logic [31:0]        mem_hl   [TableDepth*MaxFirstHops];

    logic [31:0]        rd_src, rd_seq, rd_time, rd_hl;
    logic [7:0]         rd_hops, rd_bc;
    logic [HopCntW-1:0] rd_hcnt;
    logic [SlotW-1:0]   rd_addr;

    // key read: search slot while searching, else working slot
    assign rd_addr = i_cmd.srch_rd ? srch_slot : r_slot;

    // admission state
    logic               r_found_new;   // hop already listed
    logic [HopIdxW:0]   r_hidx;
    logic [7:0]         n_hops_min;
    logic [31:0]        n_time_min;
    logic [15:0]        fac;
    logic [23:0]        r_p_hops;
    logic [47:0]        r_p_time;
    logic               adm_ok, bc_ok;
    logic               hop_new;

    assign hop_new = (r_hop != r_invalid) && (rd_hcnt < HopCntW'(MaxFirstHops))
                     && !r_found_new;
    assign fac = hop_new ? r_factor_new : r_factor_same;
    assign adm_ok = ({8'd0, r_hops, 8'd0} <= r_p_hops)
                 && ({8'd0, r_time, 8'd0} <= r_p_time);
    assign bc_ok = {1'b0, rd_bc} < r_bcast_limit;
    assign n_hops_min = (r_hops < rd_hops) ? r_hops : rd_hops;
    assign n_time_min = (r_time < rd_time) ? r_time : rd_time;

    always_ff @(posedge i_clk) begin
        rd_src  <= mem_src[rd_addr];
        rd_seq  <= mem_seq[rd_addr];
        rd_hops <= mem_hops[r_slot];
        rd_time <= mem_time[r_slot];
        rd_bc   <= mem_bc[r_slot];
        rd_hcnt <= mem_hcnt[r_slot];
        rd_hl   <= mem_hl[{r_slot, r_hidx[HopIdxW-1:0]}];
        if (i_cmd.create) begin
            mem_src[new_slot]  <= r_src;
            mem_seq[new_slot]  <= r_seq;
            mem_hops[new_slot] <= (r_cmd == CmdAccept) ? r_hops : 8'd0;
            mem_time[new_slot] <= (r_cmd == CmdAccept) ? r_time : 32'd0;
            mem_bc[new_slot]   <= '0;
            mem_hcnt[new_slot] <= '0;
        end
        if (i_cmd.decide) begin
            if (r_cmd == CmdAccept) begin
                if (adm_ok) begin
                    mem_hops[r_slot] <= n_hops_min;
                    mem_time[r_slot] <= n_time_min;
                end
            end else if (!r_bcast_limit[8] && bc_ok) begin
                mem_bc[r_slot] <= rd_bc + 8'd1;
            end
        end
        // a fresh hop of an accept request is always recorded on a new entry, on a known one only when admitted
        if (i_cmd.note_hop && hop_new && (o_new_generation || adm_ok)) begin
            mem_hl[{r_slot, rd_hcnt[HopIdxW-1:0]}] <= r_hop;
            mem_hcnt[r_slot] <= rd_hcnt + HopCntW'(1);
        end
        if (i_cmd.mul) begin
            r_p_hops <= fac * rd_hops;
            r_p_time <= fac * rd_time;
        end
    end

    // pointers, search and hop scan
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oldest <= '0;
            r_live   <= '0;
            r_idx    <= '0;
            r_slot   <= '0;
            r_hidx   <= '0;
            r_found_new <= 1'b0;
            o_admitted  <= 1'b0;
            o_new_generation <= 1'b0;
        end else begin
            if (i_cmd.srch_start) r_idx <= '0;
            if (i_cmd.srch_next) r_idx <= r_idx + CountW'(1);
            if (i_cmd.srch_rd) r_slot <= srch_slot;
            if (i_cmd.evict) begin
                r_oldest <= r_oldest + SlotW'(1);
                r_live   <= r_live - CountW'(1);
            end
            if (i_cmd.create) begin
                r_slot <= new_slot;
                r_live <= r_live + CountW'(1);
            end
            if (i_cmd.load) begin
                o_new_generation <= 1'b0;
                o_admitted <= 1'b0;
            end
            if (i_cmd.create) o_new_generation <= 1'b1;
            if (i_cmd.hop_start) begin
                r_hidx <= '0;
                r_found_new <= 1'b0;
            end
            if (i_cmd.hop_next) begin
                r_hidx <= r_hidx + (HopIdxW+1)'(1);
                if (rd_hl == r_hop) r_found_new <= 1'b1;
            end
            if (i_cmd.decide) begin
                if (r_cmd == CmdAccept) o_admitted <= o_new_generation | adm_ok;
                else o_admitted <= r_bcast_limit[8] | bc_ok;
            end
        end
    end

    assign o_stat.is_bcast    = (r_cmd == CmdBroadcast);
    assign o_stat.bcast_unlim = r_bcast_limit[8];
    assign o_stat.srch_done   = (r_idx >= r_live);
    assign o_stat.key_hit     = (rd_src == r_src) && (rd_seq == r_seq);
    assign o_stat.full        = (r_live >= cap);
    assign o_stat.hop_done    = ({1'b0, r_hidx} >= (HopIdxW+2)'(rd_hcnt));
    assign o_stat.hop_hit     = (rd_hl == r_hop);

endmodule

[hdl/gat_ctrl.sv]
// controller state machine sequencing search, evict, create, hop scan, multiply and decision
module gat_ctrl import gat_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    output logic  o_valid,
    input  logic  i_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [11:0] {
        S_IDLE   = 12'b000000000001,
        S_SRCH   = 12'b000000000010,
        S_SWAIT  = 12'b000000000100,
        S_SCHK   = 12'b000000001000,
        S_EVICT  = 12'b000000010000,
        S_CREATE = 12'b000000100000,
        S_HREAD  = 12'b000001000000,
        S_HWAIT  = 12'b000010000000,
        S_HCHK   = 12'b000100000000,
        S_MUL    = 12'b001000000000,
        S_DECIDE = 12'b010000000000,
        S_OUT    = 12'b100000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_created;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_created <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_IDLE) r_created <= 1'b0;
            if (o_cmd.create) r_created <= 1'b1;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        o_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    o_cmd.srch_start = 1'b1;
                    n_state = S_SRCH;
                end
            end
            S_SRCH: begin
                if (i_stat.is_bcast && i_stat.bcast_unlim) n_state = S_DECIDE;
                else if (i_stat.srch_done) n_state = S_EVICT;
                else begin
                    o_cmd.srch_rd = 1'b1;
                    n_state = S_SWAIT;
                end
            end
            S_SWAIT: n_state = S_SCHK;
            S_SCHK: begin
                if (i_stat.key_hit) n_state = S_HREAD;
                else begin
                    o_cmd.srch_next = 1'b1;
                    n_state = S_SRCH;
                end
            end
            S_EVICT: begin
                if (i_stat.full) o_cmd.evict = 1'b1;
                else n_state = S_CREATE;
            end
            S_CREATE: begin
                o_cmd.create = 1'b1;
                n_state = S_HREAD;
            end
            S_HREAD: begin
                o_cmd.hop_start = 1'b1;
                n_state = S_HWAIT;
            end
            S_HWAIT: n_state = S_HCHK;
            S_HCHK: begin
                if (i_stat.hop_done) n_state = S_MUL;
                else begin
                    o_cmd.hop_next = 1'b1;
                    n_state = S_HWAIT;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                o_cmd.note_hop = !i_stat.is_bcast;
                n_state = S_OUT;
            end
            S_OUT: begin
                o_valid = 1'b1;
                if (i_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // checks
    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> o_valid) else $error("result dropped");
    a_one_create: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.create && r_created) |-> 1'b0) else $error("double create");
    a_no_evict_create: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.evict && o_cmd.create)) else $error("evict with create");

endmodule

[hdl/generation_admission_table_unit.sv]
// top level of the generation admission table
//  channel | signals                                  | direction
//  cfg     | i_cfg_we, i_cfg_index, i_cfg_data        | in, plain write
//  request | i_valid/o_ready, i_command .. i_first_hop | in
//  result  | o_valid/i_ready, o_admitted, o_new_gen    | out
// an item searches the live entries in turn (one memory read port), evicts the oldest
// entries while the table is at or above its cap, creates one on a miss and scans the
// listed first hops; the worst case is a miss on 64 live entries after the cap drops to 1
// one request is processed at a time; the result stays until transferred
// synchronous active-low reset empties the table; no clearing pass is needed
module generation_admission_table_unit import gat_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_command,
    input  logic [31:0] i_source_address,
    input  logic [31:0] i_sequence_number,
    input  logic [7:0]  i_hop_count,
    input  logic [31:0] i_travel_time,
    input  logic [31:0] i_first_hop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_admitted,
    output logic        o_new_generation
);

    t_cmd  cmd;
    t_stat stat;

    gat_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .o_valid, .i_ready,
        .i_stat(stat), .o_cmd(cmd)
    );

    gat_datapath u_dp (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_command, .i_source_address, .i_sequence_number, .i_hop_count,
        .i_travel_time, .i_first_hop, .i_cmd(cmd), .o_stat(stat),
        .o_admitted, .o_new_generation
    );

endmodule

[tb/testbench.sv]
// self-checking testbench for the generation admission table unit
`timescale 1ns / 1ps

module testbench;
    import gat_pkg::*;

    localparam int HoldLimit = 20000;
    localparam int VerdictDepth = 16;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_data;
    logic        i_valid;
    logic        o_ready;
    logic        i_command;
    logic [31:0] i_source_address;
    logic [31:0] i_sequence_number;
    logic [7:0]  i_hop_count;
    logic [31:0] i_travel_time;
    logic [31:0] i_first_hop;
    logic        o_valid;
    logic        i_ready;
    logic        o_admitted;
    logic        o_new_generation;

    generation_admission_table_unit u_top (.*);

    // clock
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // predictor state
    logic [15:0] fac_same, fac_new;
    logic [8:0]  bc_limit;
    logic [6:0]  cap_reg;
    logic [31:0] inval_addr;
    logic [31:0] tbl_src [TableDepth];
    logic [31:0] tbl_seq [TableDepth];
    logic [7:0]  tbl_hops [TableDepth];
    logic [31:0] tbl_time [TableDepth];
    logic [7:0]  tbl_bcast [TableDepth];
    int          tbl_nhop [TableDepth];
    logic [31:0] tbl_hoplist [TableDepth][MaxFirstHops];
    int          ring_head, ring_live;

    typedef struct packed {
        logic admitted;
        logic new_gen;
    } t_verdict;

    // expected results in transfer order
    t_verdict verdict_buf [VerdictDepth];
    int       vb_wr, vb_rd;
    int       err_count;
    int       sent_count;
    bit       no_idle;
    bit       hold_rx;

    // key pool so that most requests hit known generations
    logic [31:0] key_src [16];
    logic [31:0] key_seq [16];

    function automatic void stash_verdict(t_verdict v);
        verdict_buf[vb_wr % VerdictDepth] = v;
        vb_wr++;
    endfunction

    function automatic t_verdict next_verdict();
        t_verdict v;
        v = verdict_buf[vb_rd % VerdictDepth];
        vb_rd++;
        return v;
    endfunction

    function automatic int locate(logic [31:0] src, logic [31:0] seq);
        int s;
        for (int k = 0; k < ring_live; k++) begin
            s = (ring_head + k) % TableDepth;
            if (tbl_src[s] == src && tbl_seq[s] == seq) return s;
        end
        return -1;
    endfunction

    function automatic int make_entry(logic [31:0] src, logic [31:0] seq,
                                      logic [7:0] hops, logic [31:0] tm);
        int lim;
        int s;
        lim = (cap_reg == 0 || cap_reg > TableDepth) ? TableDepth : int'(cap_reg);
        while (ring_live >= lim) begin
            ring_head = (ring_head + 1) % TableDepth;
            ring_live--;
        end
        s = (ring_head + ring_live) % TableDepth;
        ring_live++;
        tbl_src[s] = src;
        tbl_seq[s] = seq;
        tbl_hops[s] = hops;
        tbl_time[s] = tm;
        tbl_bcast[s] = 8'd0;
        tbl_nhop[s] = 0;
        return s;
    endfunction

    function automatic bit fresh_hop(int s, logic [31:0] hop);
        if (hop == inval_addr) return 1'b0;
        if (tbl_nhop[s] >= MaxFirstHops) return 1'b0;
        for (int i = 0; i < tbl_nhop[s]; i++)
            if (tbl_hoplist[s][i] == hop) return 1'b0;
        return 1'b1;
    endfunction

    function automatic void record_hop(int s, logic [31:0] hop);
        if (fresh_hop(s, hop)) begin
            tbl_hoplist[s][tbl_nhop[s]] = hop;
            tbl_nhop[s]++;
        end
    endfunction

    function automatic t_verdict admit_request(logic cmd, logic [31:0] src,
                                               logic [31:0] seq, logic [7:0] hops,
                                               logic [31:0] tm, logic [31:0] hop);
        t_verdict v;
        int s;
        logic [63:0] f;
        v = '0;
        s = locate(src, seq);
        if (cmd == CmdAccept) begin
            if (s < 0) begin
                s = make_entry(src, seq, hops, tm);
                record_hop(s, hop);
                v.admitted = 1'b1;
                v.new_gen = 1'b1;
            end else begin
                f = fresh_hop(s, hop) ? 64'(fac_new) : 64'(fac_same);
                if ((64'(hops) << 8) <= f * 64'(tbl_hops[s]) &&
                    (64'(tm) << 8) <= f * 64'(tbl_time[s])) begin
                    if (hops < tbl_hops[s]) tbl_hops[s] = hops;
                    if (tm < tbl_time[s]) tbl_time[s] = tm;
                    record_hop(s, hop);
                    v.admitted = 1'b1;
                end
            end
        end else if (bc_limit[8]) begin
            v.admitted = 1'b1;
        end else begin
            if (s < 0) begin
                s = make_entry(src, seq, 8'd0, 32'd0);
                v.new_gen = 1'b1;
            end
            if (9'(tbl_bcast[s]) < bc_limit) begin
                tbl_bcast[s]++;
                v.admitted = 1'b1;
            end
        end
        return v;
    endfunction

    // register write while idle
    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            RegFactorSame: fac_same = val[15:0];
            RegFactorNew:  fac_new = val[15:0];
            RegBcastLimit: bc_limit = val[8:0];
            RegEntryCap:   cap_reg = val[6:0];
            RegInvalid:    inval_addr = val;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // wait until every expected result came back, then let the block settle
    task automatic drain;
        i_valid <= 1'b0;
        while (vb_wr != vb_rd) @(posedge i_clk);
        repeat (250) @(posedge i_clk);
    endtask

    // send one request and queue its prediction
    task automatic send_req(logic cmd, logic [31:0] src, logic [31:0] seq,
                            logic [7:0] hops, logic [31:0] tm, logic [31:0] hop);
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_command <= cmd;
        i_source_address <= src;
        i_sequence_number <= seq;
        i_hop_count <= hops;
        i_travel_time <= tm;
        i_first_hop <= hop;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        stash_verdict(admit_request(cmd, src, seq, hops, tm, hop));
        sent_count++;
    endtask

    task automatic send_random(int pool);
        int k;
        logic cmd;
        logic [31:0] hop;
        k = $urandom_range(0, pool - 1);
        cmd = ($urandom_range(0, 4) == 0) ? CmdBroadcast : CmdAccept;
        case ($urandom_range(0, 3))
            0: hop = inval_addr;
            1: hop = $urandom;
            default: hop = 32'(100 + $urandom_range(0, 5));
        endcase
        if ($urandom_range(0, 9) == 0)
            send_req(cmd, $urandom, $urandom, 8'($urandom), $urandom, hop);
        else
            send_req(cmd, key_src[k], key_seq[k], 8'($urandom_range(1, 20)),
                     ($urandom_range(0, 7) == 0) ? $urandom : 32'($urandom_range(1, 4000)),
                     hop);
    endtask

    task automatic new_keys;
        for (int i = 0; i < 16; i++) begin
            key_src[i] = $urandom;
            key_seq[i] = $urandom;
        end
    endtask

    // field extremes, both commands and broadcast special cases
    task automatic test_directed;
        send_req(CmdAccept, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF, 32'h0);
        send_req(CmdAccept, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF, 32'h1);
        send_req(CmdAccept, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'h0, 32'h0, 32'hFFFF_FFFF);
        send_req(CmdAccept, 32'h0, 32'h0, 8'h0, 32'h0, 32'h0);
        send_req(CmdAccept, 32'h0, 32'h0, 8'h1, 32'h0, 32'h5);
        send_req(CmdAccept, 32'h0, 32'h0, 8'h0, 32'h0, 32'h6);
        send_req(CmdBroadcast, 32'h0, 32'h0, 8'h0, 32'h0, 32'h0);
        send_req(CmdAccept, 32'h1, 32'h2, 8'd10, 32'd1000, 32'd7);
        send_req(CmdAccept, 32'h1, 32'h2, 8'd15, 32'd1500, 32'd7);
        send_req(CmdAccept, 32'h1, 32'h2, 8'd16, 32'd1500, 32'd7);
        send_req(CmdAccept, 32'h1, 32'h2, 8'd20, 32'd2000, 32'd8);
        send_req(CmdAccept, 32'h1, 32'h2, 8'd9, 32'd900, 32'd9);
        send_req(CmdAccept, 32'h1, 32'h2, 8'd9, 32'd900, 32'd10);
        send_req(CmdAccept, 32'h1, 32'h2, 8'd9, 32'd900, 32'd11);
        drain();
        write_reg(RegBcastLimit, 32'd2);
        send_req(CmdBroadcast, 32'h1, 32'h2, 8'h0, 32'h0, 32'h0);
        send_req(CmdBroadcast, 32'h1, 32'h2, 8'h0, 32'h0, 32'h0);
        send_req(CmdBroadcast, 32'h1, 32'h2, 8'h0, 32'h0, 32'h0);
        send_req(CmdBroadcast, 32'h33, 32'h44, 8'h0, 32'h0, 32'h0);
        send_req(CmdAccept, 32'h33, 32'h44, 8'h0, 32'h0, 32'h0);
        send_req(CmdAccept, 32'h33, 32'h44, 8'h1, 32'h0, 32'h1);
        drain();
        write_reg(RegBcastLimit, 32'd0);
        send_req(CmdBroadcast, 32'h55, 32'h66, 8'h0, 32'h0, 32'h0);
        drain();
    endtask

    // eviction under small caps, including lowering the cap below the live count
    task automatic test_eviction;
        write_reg(RegEntryCap, 32'd1);
        for (int i = 0; i < 4; i++)
            send_req(CmdAccept, 32'(i), 32'd9, 8'd3, 32'd30, 32'd1);
        drain();
        write_reg(RegEntryCap, 32'd127);
        for (int i = 0; i < 70; i++)
            send_req(CmdAccept, 32'(200 + i), 32'd1, 8'd3, 32'd30, 32'd1);
        drain();
        write_reg(RegEntryCap, 32'd3);
        for (int i = 0; i < 8; i++)
            send_req(CmdAccept, 32'(200 + 66 + i % 5), 32'd1, 8'd3, 32'd30, 32'd2);
        drain();
    endtask

    // random phases over several register settings
    task automatic test_random_phases;
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(RegFactorSame, (ph == 0) ? 32'd0 : (ph == 1) ? 32'hFFFF
                                     : 32'($urandom_range(256, 600)));
            write_reg(RegFactorNew, (ph == 1) ? 32'd0 : (ph == 2) ? 32'hFFFF
                                    : 32'($urandom_range(256, 900)));
            write_reg(RegBcastLimit, (ph == 3) ? 32'd255 : (ph % 3 == 0) ? 32'h1FF
                                     : 32'($urandom_range(0, 4)));
            write_reg(RegEntryCap, (ph == 4) ? 32'd64 : (ph == 5) ? 32'd0
                                   : 32'($urandom_range(1, 12)));
            write_reg(RegInvalid, (ph == 6) ? 32'd0 : (ph == 7) ? 32'd101 : 32'hFFFF_FFFF);
            new_keys();
            for (int i = 0; i < 140; i++) send_random(16);
            drain();
        end
    endtask

    // receiver holds off while the sender keeps offering
    task automatic test_backpressure;
        hold_rx = 1'b1;
        for (int i = 0; i < 6; i++) send_random(16);
        hold_rx = 1'b0;
        drain();
    endtask

    // closing stretch with no idling
    task automatic test_no_idle;
        no_idle = 1'b1;
        new_keys();
        for (int i = 0; i < 180; i++) send_random(8);
        drain();
    endtask

    // result side: random stall bursts, long hold-off on request
    initial begin
        int hold;
        i_ready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_rx) begin
                i_ready <= 1'b0;
                hold = 0;
                while (hold < 2000) begin
                    @(posedge i_clk);
                    hold++;
                end
                i_ready <= 1'b1;
                while (hold_rx) @(posedge i_clk);
            end else if (!no_idle && $urandom_range(0, 7) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
                i_ready <= 1'b1;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // result check
    always @(posedge i_clk) begin
        t_verdict v;
        if (i_rst_n && o_valid && i_ready) begin
            if (vb_wr == vb_rd) begin
                $error("result transfer with nothing expected");
                err_count++;
            end else begin
                v = next_verdict();
                if (o_admitted !== v.admitted) begin
                    $error("admitted: expected %0b actual %0b", v.admitted, o_admitted);
                    err_count++;
                end
                if (o_new_generation !== v.new_gen) begin
                    $error("new_generation: expected %0b actual %0b", v.new_gen,
                           o_new_generation);
                    err_count++;
                end
            end
        end
    end

    // watchdog on cycles with no transfer
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready) || i_cfg_we) quiet = 0;
            else quiet++;
            if (quiet >= HoldLimit) begin
                $display("generation_admission_table_unit verification failed");
                $finish;
            end
        end
    end

    // main sequence
    initial begin
        err_count = 0;
        sent_count = 0;
        vb_wr = 0;
        vb_rd = 0;
        no_idle = 1'b0;
        hold_rx = 1'b0;
        fac_same = 16'd384;
        fac_new = 16'd512;
        bc_limit = 9'h1FF;
        cap_reg = 7'd0;
        inval_addr = 32'hFFFF_FFFF;
        ring_head = 0;
        ring_live = 0;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_index <= RegFactorSame;
        i_cfg_data <= 32'd0;
        i_valid <= 1'b0;
        i_command <= CmdAccept;
        i_source_address <= 32'd0;
        i_sequence_number <= 32'd0;
        i_hop_count <= 8'd0;
        i_travel_time <= 32'd0;
        i_first_hop <= 32'd0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_eviction();
        test_random_phases();
        test_backpressure();
        test_no_idle();
        if (err_count == 0 && vb_wr == vb_rd)
            $display("generation_admission_table_unit verification clean");
        else
            $display("generation_admission_table_unit verification failed");
        $finish;
    end

endmodule

[filelist.f]
hdl/gat_pkg.sv
hdl/gat_datapath.sv
hdl/gat_ctrl.sv
hdl/generation_admission_table_unit.sv
tb/testbench.sv
